// ===== rtl/gba_pkg.sv =====
`default_nettype none
// ----------------------------------------------------------------------------
// gba_pkg
// Shared constants, status codes and helpers for the grouped bitmap allocator.
// ----------------------------------------------------------------------------
package gba_pkg;

    localparam int ITEMS_PER_GROUP = 8192;
    localparam int MAX_GROUPS      = 16;
    localparam int WORD_W          = 32;
    localparam int BIT_W           = $clog2(WORD_W);
    localparam int WORDS_PER_GROUP = ITEMS_PER_GROUP / WORD_W;
    localparam int WIDX_W          = $clog2(WORDS_PER_GROUP);
    localparam int GROUP_W         = $clog2(MAX_GROUPS);
    localparam int ITEM_W          = GROUP_W + WIDX_W + BIT_W;
    localparam int BM_DEPTH        = MAX_GROUPS * WORDS_PER_GROUP;
    localparam int BM_AW           = $clog2(BM_DEPTH);
    localparam int CNT_W           = $clog2(ITEMS_PER_GROUP) + 1;
    localparam int CFG_W           = 5;
    localparam int STATUS_W        = 3;
    localparam int CFG_RESET       = 16;

    localparam logic ACT_ALLOC = 1'b0;
    localparam logic ACT_FREE  = 1'b1;

    typedef enum logic [STATUS_W-1:0] {
        ST_ALLOCATED    = 3'd0,
        ST_FREED        = 3'd1,
        ST_NO_FREE      = 3'd2,
        ST_ALREADY_FREE = 3'd3,
        ST_BAD_GROUP    = 3'd4
    } t_status;

    // index of the lowest clear bit; only meaningful when one exists
    function automatic logic [BIT_W-1:0] lowest_clear(input logic [WORD_W-1:0] word);
        logic [BIT_W-1:0] idx;
        idx = '0;
        for (int k = WORD_W - 1; k >= 0; k--) begin
            if (!word[k]) begin
                idx = BIT_W'(k);
            end
        end
        return idx;
    endfunction

endpackage
`default_nettype wire

// ===== rtl/gba_ram.sv =====
`default_nettype none
// ----------------------------------------------------------------------------
// gba_ram
// Generic simple dual-port RAM, one write port, one registered read port.
// ----------------------------------------------------------------------------
module gba_ram #(
    parameter int WIDTH = 32,
    parameter int DEPTH = 256
) (
    input  wire logic                     i_clk,
    input  wire logic                     i_we,
    input  wire logic [$clog2(DEPTH)-1:0] i_waddr,
    input  wire logic [WIDTH-1:0]         i_wdata,
    input  wire logic                     i_re,
    input  wire logic [$clog2(DEPTH)-1:0] i_raddr,
    output logic      [WIDTH-1:0]         o_rdata
);

    logic [WIDTH-1:0] r_mem [DEPTH];
    logic [WIDTH-1:0] r_rdata;

    always_ff @(posedge i_clk) begin
        if (i_we) begin
            r_mem[i_waddr] <= i_wdata;
        end
        if (i_re) begin
            r_rdata <= r_mem[i_raddr];
        end
    end

    assign o_rdata = r_rdata;

endmodule
`default_nettype wire

// ===== rtl/grouped_bitmap_allocator_unit.sv =====
`default_nettype none
// ----------------------------------------------------------------------------
// grouped_bitmap_allocator_unit
// Allocates and frees items from a usage bitmap split into groups, each
// group with its own free count. Bitmap and counts live in synchronous RAMs.
// ----------------------------------------------------------------------------
// channel   direction  ports                                        beat
// command   in         start/busy, i_action, i_start_group,         start & !busy
//                      i_item_number
// result    out        o_valid, o_status, o_allocated_item,         o_valid (1 cycle)
//                      o_group_free_count
// config    in         i_cfg_we, i_cfg_wdata                        i_cfg_we
//
// Free: read bitmap word and group count, then check and write back. Allocate:
// start-group reduction by repeated subtraction, then per group visited a count
// lookup and a scan of up to 256 bitmap words; the single bitmap read port sets the scan rate.
// After reset a clearing pass over all 4096 bitmap words zeroes the bitmap, busy high.
// One result per command, no back-pressure on the result side.
// ----------------------------------------------------------------------------
module grouped_bitmap_allocator_unit (
    input  wire logic                          i_clk,
    input  wire logic                          i_rst_n,
    input  wire logic                          start,
    output logic                               busy,
    input  wire logic                          i_action,
    input  wire logic [gba_pkg::GROUP_W-1:0]   i_start_group,
    input  wire logic [gba_pkg::ITEM_W-1:0]    i_item_number,
    input  wire logic                          i_cfg_we,
    input  wire logic [gba_pkg::CFG_W-1:0]     i_cfg_wdata,
    output logic                               o_valid,
    output logic [gba_pkg::STATUS_W-1:0]       o_status,
    output logic [gba_pkg::ITEM_W-1:0]         o_allocated_item,
    output logic [gba_pkg::CNT_W-1:0]          o_group_free_count
);
    import gba_pkg::*;

    typedef enum logic [6:0] {
        S_CLEAR  = 7'b0000001,
        S_IDLE   = 7'b0000010,
        S_A_MOD  = 7'b0000100,
        S_A_CNT  = 7'b0001000,
        S_A_CHK  = 7'b0010000,
        S_A_SCAN = 7'b0100000,
        S_F_CHK  = 7'b1000000
    } t_state;

    t_state              r_state, n_state;
    logic [BM_AW-1:0]    r_clr, n_clr;
    logic [CFG_W-1:0]    r_cfg;
    logic [GROUP_W-1:0]  r_g, n_g;
    logic [GROUP_W-1:0]  r_start, n_start;
    logic [WIDX_W-1:0]   r_w, n_w;
    logic [CNT_W-1:0]    r_cnt, n_cnt;
    logic [ITEM_W-1:0]   r_item, n_item;
    logic                r_valid, n_valid;
    t_status             r_status, n_status;
    logic [ITEM_W-1:0]   r_res_item, n_res_item;
    logic [CNT_W-1:0]    r_res_cnt, n_res_cnt;

    logic                bm_we, bm_re;
    logic [BM_AW-1:0]    bm_waddr, bm_raddr;
    logic [WORD_W-1:0]   bm_wdata, bm_rdata;
    logic                fc_we, fc_re;
    logic [GROUP_W-1:0]  fc_waddr, fc_raddr;
    logic [CNT_W-1:0]    fc_wdata, fc_rdata;

    logic [CFG_W-1:0]    n_eff;
    logic [GROUP_W:0]    g_inc;
    logic [GROUP_W-1:0]  g_next;
    logic [BIT_W-1:0]    bidx;
    logic [GROUP_W-1:0]  f_group;
    logic [BIT_W-1:0]    f_bit;

    gba_ram #(
        .WIDTH (WORD_W),
        .DEPTH (BM_DEPTH)
    ) u_bitmap (
        .i_clk   (i_clk),
        .i_we    (bm_we),
        .i_waddr (bm_waddr),
        .i_wdata (bm_wdata),
        .i_re    (bm_re),
        .i_raddr (bm_raddr),
        .o_rdata (bm_rdata)
    );

    gba_ram #(
        .WIDTH (CNT_W),
        .DEPTH (MAX_GROUPS)
    ) u_counts (
        .i_clk   (i_clk),
        .i_we    (fc_we),
        .i_waddr (fc_waddr),
        .i_wdata (fc_wdata),
        .i_re    (fc_re),
        .i_raddr (fc_raddr),
        .o_rdata (fc_rdata)
    );

    always_comb begin
        if (r_cfg == '0) begin
            n_eff = CFG_W'(1);
        end else if (r_cfg > CFG_W'(MAX_GROUPS)) begin
            n_eff = CFG_W'(MAX_GROUPS);
        end else begin
            n_eff = r_cfg;
        end
    end

    assign g_inc   = {1'b0, r_g} + (GROUP_W+1)'(1);
    assign g_next  = (CFG_W'(g_inc) == n_eff) ? '0 : g_inc[GROUP_W-1:0];
    assign bidx    = lowest_clear(bm_rdata);
    assign f_group = r_item[ITEM_W-1 -: GROUP_W];
    assign f_bit   = r_item[BIT_W-1:0];

    always_comb begin
        n_state    = r_state;
        n_clr      = r_clr;
        n_g        = r_g;
        n_start    = r_start;
        n_w        = r_w;
        n_cnt      = r_cnt;
        n_item     = r_item;
        n_valid    = 1'b0;
        n_status   = r_status;
        n_res_item = r_res_item;
        n_res_cnt  = r_res_cnt;
        bm_we      = 1'b0;
        bm_waddr   = {r_g, r_w};
        bm_wdata   = '0;
        bm_re      = 1'b0;
        bm_raddr   = {r_g, r_w};
        fc_we      = 1'b0;
        fc_waddr   = r_g;
        fc_wdata   = '0;
        fc_re      = 1'b0;
        fc_raddr   = r_g;

        unique case (r_state)
            S_CLEAR: begin
                bm_we    = 1'b1;
                bm_waddr = r_clr;
                bm_wdata = '0;
                if (r_clr < BM_AW'(MAX_GROUPS)) begin
                    fc_we    = 1'b1;
                    fc_waddr = r_clr[GROUP_W-1:0];
                    fc_wdata = CNT_W'(ITEMS_PER_GROUP);
                end
                n_clr = r_clr + BM_AW'(1);
                if (r_clr == '1) begin
                    n_state = S_IDLE;
                end
            end
            S_IDLE: begin
                if (start) begin
                    if (i_action == ACT_FREE) begin
                        bm_re    = 1'b1;
                        bm_raddr = i_item_number[ITEM_W-1:BIT_W];
                        fc_re    = 1'b1;
                        fc_raddr = i_item_number[ITEM_W-1 -: GROUP_W];
                        n_item   = i_item_number;
                        n_state  = S_F_CHK;
                    end else begin
                        n_g     = i_start_group;
                        n_state = S_A_MOD;
                    end
                end
            end
            S_A_MOD: begin
                if (CFG_W'(r_g) >= n_eff) begin
                    n_g = GROUP_W'(CFG_W'(r_g) - n_eff);
                end else begin
                    n_start = r_g;
                    n_state = S_A_CNT;
                end
            end
            S_A_CNT: begin
                fc_re    = 1'b1;
                fc_raddr = r_g;
                bm_re    = 1'b1;
                bm_raddr = {r_g, WIDX_W'(0)};
                n_state  = S_A_CHK;
            end
            S_A_CHK: begin
                n_cnt = fc_rdata;
                n_w   = '0;
                if (fc_rdata == '0) begin
                    if (g_next == r_start) begin
                        n_valid    = 1'b1;
                        n_status   = ST_NO_FREE;
                        n_res_item = '0;
                        n_res_cnt  = '0;
                        n_state    = S_IDLE;
                    end else begin
                        n_g     = g_next;
                        n_state = S_A_CNT;
                    end
                end else begin
                    n_state = S_A_SCAN;
                end
            end
            S_A_SCAN: begin
                if (~bm_rdata != '0) begin
                    bm_we      = 1'b1;
                    bm_waddr   = {r_g, r_w};
                    bm_wdata   = bm_rdata | (WORD_W'(1) << bidx);
                    fc_we      = 1'b1;
                    fc_waddr   = r_g;
                    fc_wdata   = r_cnt - CNT_W'(1);
                    n_valid    = 1'b1;
                    n_status   = ST_ALLOCATED;
                    n_res_item = {r_g, r_w, bidx};
                    n_res_cnt  = r_cnt - CNT_W'(1);
                    n_state    = S_IDLE;
                end else if (r_w == '1) begin
                    if (g_next == r_start) begin
                        n_valid    = 1'b1;
                        n_status   = ST_NO_FREE;
                        n_res_item = '0;
                        n_res_cnt  = '0;
                        n_state    = S_IDLE;
                    end else begin
                        n_g     = g_next;
                        n_state = S_A_CNT;
                    end
                end else begin
                    bm_re    = 1'b1;
                    bm_raddr = {r_g, r_w + WIDX_W'(1)};
                    n_w      = r_w + WIDX_W'(1);
                end
            end
            S_F_CHK: begin
                n_valid    = 1'b1;
                n_res_item = '0;
                n_state    = S_IDLE;
                if (CFG_W'(f_group) >= n_eff) begin
                    n_status  = ST_BAD_GROUP;
                    n_res_cnt = '0;
                end else if (!bm_rdata[f_bit]) begin
                    n_status  = ST_ALREADY_FREE;
                    n_res_cnt = fc_rdata;
                end else begin
                    bm_we    = 1'b1;
                    bm_waddr = r_item[ITEM_W-1:BIT_W];
                    bm_wdata = bm_rdata & ~(WORD_W'(1) << f_bit);
                    fc_we    = 1'b1;
                    fc_waddr = f_group;
                    if (fc_rdata < CNT_W'(ITEMS_PER_GROUP)) begin
                        fc_wdata = fc_rdata + CNT_W'(1);
                    end else begin
                        fc_wdata = fc_rdata;
                    end
                    n_status  = ST_FREED;
                    n_res_cnt = fc_wdata;
                end
            end
            default: begin
                n_state = S_IDLE;
            end
        endcase
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state <= S_CLEAR;
            r_clr   <= '0;
            r_cfg   <= CFG_W'(CFG_RESET);
            r_valid <= 1'b0;
        end else begin
            r_state <= n_state;
            r_clr   <= n_clr;
            r_valid <= n_valid;
            if (i_cfg_we) begin
                r_cfg <= i_cfg_wdata;
            end
        end
    end

    always_ff @(posedge i_clk) begin
        r_g        <= n_g;
        r_start    <= n_start;
        r_w        <= n_w;
        r_cnt      <= n_cnt;
        r_item     <= n_item;
        r_status   <= n_status;
        r_res_item <= n_res_item;
        r_res_cnt  <= n_res_cnt;
    end

    assign busy               = (r_state != S_IDLE);
    assign o_valid            = r_valid;
    assign o_status           = r_status;
    assign o_allocated_item   = r_res_item;
    assign o_group_free_count = r_res_cnt;

    a_result_after_work: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        o_valid |-> $past(busy))
        else $error("result strobe without a command in flight");

    a_single_strobe: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        o_valid |=> !o_valid)
        else $error("result strobe held for more than one beat");

    a_accept_goes_busy: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (start && !busy) |=> busy)
        else $error("command accepted but unit not busy");

    a_item_only_on_alloc: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (o_valid && o_status != ST_ALLOCATED) |-> (o_allocated_item == '0))
        else $error("item number reported without allocation");

    a_alloc_count_below_full: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (o_valid && o_status == ST_ALLOCATED) |->
            (o_group_free_count < CNT_W'(ITEMS_PER_GROUP)))
        else $error("allocation left group count at full");

endmodule
`default_nettype wire

// ===== tb/sv/grouped_bitmap_allocator_unit_tb.sv =====
`default_nettype none
// ----------------------------------------------------------------------------
// grouped_bitmap_allocator_unit_tb
// Self-checking bench for the grouped bitmap allocator. A queue-fed driver
// issues allocate/free commands and register writes with random gaps. A
// monitor keeps its own copy of the bitmap and per-group free counts,
// predicts each result at the command beat, and checks every result beat
// field by field. The stimulus covers register extremes, a long run of
// allocations in one group, deep scans, bad groups and double frees, then
// random batches.
// ----------------------------------------------------------------------------
module grouped_bitmap_allocator_unit_tb;
    import gba_pkg::*;

    localparam int RANDOM_ITEMS = 1050;
    localparam int FILL_ITEMS   = 640;
    localparam int ITEM_SPACE   = ITEMS_PER_GROUP * MAX_GROUPS;
    localparam int CYCLE_LIMIT  =
        4096 + 3 * 2000 * (15 + MAX_GROUPS * (2 + WORDS_PER_GROUP) + 48);

    typedef struct packed {
        t_status             status;
        logic [ITEM_W-1:0]   item;
        logic [CNT_W-1:0]    count;
    } t_alloc_reply;

    typedef struct packed {
        logic                is_cfg;
        logic [CFG_W-1:0]    cfg_value;
        logic                act;
        logic [GROUP_W-1:0]  sg;
        logic [ITEM_W-1:0]   num;
    } t_cmd_entry;

    logic                 i_clk              = 1'b0;
    logic                 i_rst_n            = 1'b0;
    logic                 start              = 1'b0;
    logic                 busy;
    logic                 i_action           = ACT_ALLOC;
    logic [GROUP_W-1:0]   i_start_group      = '0;
    logic [ITEM_W-1:0]    i_item_number      = '0;
    logic                 i_cfg_we           = 1'b0;
    logic [CFG_W-1:0]     i_cfg_wdata        = '0;
    logic                 o_valid;
    logic [STATUS_W-1:0]  o_status;
    logic [ITEM_W-1:0]    o_allocated_item;
    logic [CNT_W-1:0]     o_group_free_count;

    // allocator shadow state
    logic [WORD_W-1:0]    usage_words [BM_DEPTH];
    int unsigned          group_free [MAX_GROUPS];
    int unsigned          groups_setting;
    int unsigned          items_in_use[$];

    t_cmd_entry           commands_pending[$];
    t_alloc_reply         replies_due[$];
    bit                   cmd_beat       = 1'b0;
    int                   mismatch_count = 0;
    int                   idle_gap       = 0;
    int                   calm_left      = 0;
    int                   cfg_settle     = 0;
    int unsigned          cycle_count    = 0;

    grouped_bitmap_allocator_unit dut (
        .i_clk              (i_clk),
        .i_rst_n            (i_rst_n),
        .start              (start),
        .busy               (busy),
        .i_action           (i_action),
        .i_start_group      (i_start_group),
        .i_item_number      (i_item_number),
        .i_cfg_we           (i_cfg_we),
        .i_cfg_wdata        (i_cfg_wdata),
        .o_valid            (o_valid),
        .o_status           (o_status),
        .o_allocated_item   (o_allocated_item),
        .o_group_free_count (o_group_free_count)
    );

    always #4 i_clk = ~i_clk;

    function automatic t_alloc_reply allocator_outcome(input logic act,
            input logic [GROUP_W-1:0] sg, input logic [ITEM_W-1:0] num);
        t_alloc_reply       r;
        int unsigned        n;
        int unsigned        first;
        int unsigned        g;
        int unsigned        pos;
        logic [WORD_W-1:0]  word;
        bit                 found;
        n = (groups_setting == 0) ? 1 :
            ((groups_setting > MAX_GROUPS) ? MAX_GROUPS : groups_setting);
        r.status = ST_NO_FREE;
        r.item   = '0;
        r.count  = '0;
        found    = 1'b0;
        pos      = 0;
        if (act == ACT_ALLOC) begin
            first = sg % n;
            g     = first;
            do begin
                if (group_free[g] != 0) begin
                    for (int w = 0; w < WORDS_PER_GROUP && !found; w++) begin
                        word = usage_words[g * WORDS_PER_GROUP + w];
                        for (int b = 0; b < WORD_W && !found && word != '1; b++) begin
                            if (!word[b]) begin
                                found = 1'b1;
                                pos   = g * ITEMS_PER_GROUP + w * WORD_W + b;
                            end
                        end
                    end
                end
                if (!found) begin
                    g = (g + 1) % n;
                end
            end while (!found && g != first);
            if (found) begin
                usage_words[pos / WORD_W][pos % WORD_W] = 1'b1;
                group_free[g]--;
                items_in_use.push_back(pos);
                r.status = ST_ALLOCATED;
                r.item   = ITEM_W'(pos);
                r.count  = CNT_W'(group_free[g]);
            end
        end else begin
            g = num / ITEMS_PER_GROUP;
            if (g >= n) begin
                r.status = ST_BAD_GROUP;
            end else if (!usage_words[num / WORD_W][num % WORD_W]) begin
                r.status = ST_ALREADY_FREE;
                r.count  = CNT_W'(group_free[g]);
            end else begin
                usage_words[num / WORD_W][num % WORD_W] = 1'b0;
                if (group_free[g] < ITEMS_PER_GROUP) begin
                    group_free[g]++;
                end
                r.status = ST_FREED;
                r.count  = CNT_W'(group_free[g]);
                for (int k = items_in_use.size() - 1; k >= 0 && !found; k--) begin
                    if (items_in_use[k] == num) begin
                        items_in_use.delete(k);
                        found = 1'b1;
                    end
                end
            end
        end
        return r;
    endfunction

    task automatic push_alloc(input int unsigned sg);
        t_cmd_entry e;
        e        = '0;
        e.act    = ACT_ALLOC;
        e.sg     = GROUP_W'(sg);
        commands_pending.push_back(e);
    endtask

    task automatic push_free(input int unsigned num);
        t_cmd_entry e;
        e        = '0;
        e.act    = ACT_FREE;
        e.sg     = GROUP_W'($urandom_range(MAX_GROUPS - 1));
        e.num    = ITEM_W'(num);
        commands_pending.push_back(e);
    endtask

    task automatic push_cfg(input int unsigned value);
        t_cmd_entry e;
        e           = '0;
        e.is_cfg    = 1'b1;
        e.cfg_value = CFG_W'(value);
        commands_pending.push_back(e);
    endtask

    // returns once nothing is queued, in flight or awaited
    task automatic wait_idle();
        do @(posedge i_clk);
        while (commands_pending.size() != 0 || start || i_cfg_we || replies_due.size() != 0);
        @(posedge i_clk);
    endtask

    always @(negedge i_clk) begin : drive_cmds
        logic        nxt_start;
        logic        nxt_we;
        t_cmd_entry  head;
        int          roll;
        nxt_start = start;
        nxt_we    = 1'b0;
        if (start && cmd_beat) begin
            nxt_start = 1'b0;
        end
        if (i_rst_n && !nxt_start && commands_pending.size() != 0) begin
            if (commands_pending[0].is_cfg) begin
                if (replies_due.size() == 0 && !start && !busy) begin
                    cfg_settle++;
                end else begin
                    cfg_settle = 0;
                end
                if (cfg_settle > 4) begin
                    head        = commands_pending.pop_front();
                    nxt_we      = 1'b1;
                    i_cfg_wdata <= head.cfg_value;
                    cfg_settle  = 0;
                end
            end else if (idle_gap > 0) begin
                idle_gap--;
            end else begin
                head          = commands_pending.pop_front();
                i_action      <= head.act;
                i_start_group <= head.sg;
                i_item_number <= head.num;
                nxt_start     = 1'b1;
                roll          = $urandom_range(99);
                if (calm_left > 0) begin
                    calm_left--;
                    idle_gap = 0;
                end else if (roll < 3) begin
                    calm_left = $urandom_range(60, 20);
                    idle_gap  = 0;
                end else if (roll < 60) begin
                    idle_gap = $urandom_range(2);
                end else if (roll < 94) begin
                    idle_gap = $urandom_range(8, 3);
                end else begin
                    idle_gap = $urandom_range(40, 10);
                end
            end
        end
        start    <= nxt_start;
        i_cfg_we <= nxt_we;
    end

    always @(posedge i_clk) begin : watch_beats
        t_alloc_reply want;
        cmd_beat = 1'b0;
        if (i_rst_n) begin
            if (i_cfg_we) begin
                groups_setting = i_cfg_wdata;
            end
            if (o_valid) begin
                if (replies_due.size() == 0) begin
                    $display("%0t: unexpected result: status %0d item %0d count %0d",
                             $time, o_status, o_allocated_item, o_group_free_count);
                    mismatch_count++;
                end else begin
                    want = replies_due.pop_front();
                    if (o_status !== want.status) begin
                        $display("%0t: status expected %0d, got %0d",
                                 $time, want.status, o_status);
                        mismatch_count++;
                    end
                    if (o_allocated_item !== want.item) begin
                        $display("%0t: allocated_item expected %0d, got %0d",
                                 $time, want.item, o_allocated_item);
                        mismatch_count++;
                    end
                    if (o_group_free_count !== want.count) begin
                        $display("%0t: group_free_count expected %0d, got %0d",
                                 $time, want.count, o_group_free_count);
                        mismatch_count++;
                    end
                end
            end
            if (start && !busy) begin
                cmd_beat = 1'b1;
                replies_due.push_back(allocator_outcome(i_action, i_start_group,
                                                        i_item_number));
            end
        end
    end

    always @(posedge i_clk) begin
        cycle_count++;
        if (cycle_count == CYCLE_LIMIT) begin
            $display("tb: failure");
            $finish;
        end
    end

    initial begin : stimulus
        int unsigned value;
        int unsigned roll;
        int unsigned lo;
        int unsigned batch;
        int unsigned random_sent;
        foreach (usage_words[w]) usage_words[w] = '0;
        foreach (group_free[g]) group_free[g] = ITEMS_PER_GROUP;
        groups_setting = CFG_RESET;
        random_sent    = 0;

        // directed: reset setting, extremes, double free, bad groups
        push_alloc(0);
        push_alloc(0);
        push_alloc(15);
        push_alloc(10);
        push_free(1);
        push_free(1);
        push_free(ITEM_SPACE - 1);
        push_free(15 * ITEMS_PER_GROUP);
        push_alloc(0);
        push_cfg(3);
        push_alloc(15);
        push_alloc(4);
        push_free(ITEM_SPACE - 1);
        push_free(3 * ITEMS_PER_GROUP);
        push_free(3 * ITEMS_PER_GROUP - 1);
        push_cfg(0);
        push_alloc(9);
        push_free(ITEMS_PER_GROUP);
        push_cfg(31);
        push_alloc(15);
        push_free(10 * ITEMS_PER_GROUP);
        push_cfg(1);

        repeat (2) @(posedge i_clk);
        @(negedge i_clk);
        i_rst_n <= 1'b1;

        // fill the low words of group 0, then deep scans and frees
        wait_idle();
        for (int k = 0; k < FILL_ITEMS; k++) begin
            push_alloc($urandom_range(MAX_GROUPS - 1));
        end
        push_alloc(7);
        push_free(ITEMS_PER_GROUP - 1);
        push_alloc(3);
        push_free(ITEMS_PER_GROUP / 2);
        push_free(0);
        push_alloc(0);
        push_alloc(0);
        push_alloc(12);
        push_cfg(2);
        push_alloc(0);
        push_cfg(MAX_GROUPS);

        while (random_sent < RANDOM_ITEMS) begin
            wait_idle();
            if ($urandom_range(99) < 35) begin
                case ($urandom_range(9))
                    0:       value = 0;
                    1:       value = $urandom_range(31, MAX_GROUPS + 1);
                    2:       value = 1;
                    3:       value = MAX_GROUPS;
                    default: value = $urandom_range(MAX_GROUPS, 1);
                endcase
                push_cfg(value);
            end
            batch = $urandom_range(70, 20);
            for (int k = 0; k < batch; k++) begin
                roll = $urandom_range(99);
                if (roll < 58) begin
                    push_alloc($urandom_range(MAX_GROUPS - 1));
                end else if (roll < 85 && items_in_use.size() != 0) begin
                    lo = (items_in_use.size() > 256) ? items_in_use.size() - 256 : 0;
                    push_free(items_in_use[$urandom_range(items_in_use.size() - 1, lo)]);
                end else begin
                    push_free($urandom_range(ITEM_SPACE - 1));
                end
            end
            random_sent += batch;
        end

        wait_idle();
        repeat (40) @(posedge i_clk);
        if (mismatch_count == 0 && replies_due.size() == 0) begin
            $display("tb: success");
        end else begin
            $display("tb: failure");
        end
        $finish;
    end

endmodule
`default_nettype wire
